// File: sv/u16u8_pkg.sv
package u16u8_pkg;

  // Default depth of the job queue between front and back
  localparam int QUEUE_DEPTH_DEF = 4;

  // Surrogate prefixes (top six bits of a code unit)
  localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
  localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;

  localparam logic [20:0] SUPP_BASE   = 21'h10000;
  localparam logic [2:0]  FLUSH_BYTES = 3'd3;

  // One job: an optional flushed high surrogate, then an optional code point
  typedef struct packed {
    logic        flush;
    logic [9:0]  flush_bits;
    logic        cur;
    logic [20:0] cp;
    logic        eot;
  } job_t;

  // Number of UTF-8 bytes for a code point
  function automatic logic [2:0] cp_len(input logic [20:0] cp);
    logic [2:0] n;
    if (cp[20:7] == 14'd0) begin
      n = 3'd1;
    end else if (cp[20:11] == 10'd0) begin
      n = 3'd2;
    end else if (cp[20:16] == 5'd0) begin
      n = 3'd3;
    end else begin
      n = 3'd4;
    end
    return n;
  endfunction

  // Byte at position pos of the len-byte encoding of cp
  function automatic logic [7:0] cp_byte(input logic [20:0] cp, input logic [2:0] len,
                                         input logic [1:0] pos);
    logic [7:0] b;
    b = {2'b10, cp[5:0]};
    case (len)
      3'd1: b = {1'b0, cp[6:0]};
      3'd2: begin
        if (pos == 2'd0) b = {3'b110, cp[10:6]};
      end
      3'd3: begin
        if (pos == 2'd0) b = {4'b1110, cp[15:12]};
        else if (pos == 2'd1) b = {2'b10, cp[11:6]};
      end
      3'd4: begin
        if (pos == 2'd0) b = {5'b11110, cp[20:18]};
        else if (pos == 2'd1) b = {2'b10, cp[17:12]};
        else if (pos == 2'd2) b = {2'b10, cp[11:6]};
      end
      default: b = {2'b10, cp[5:0]};
    endcase
    return b;
  endfunction

endpackage

// File: sv/u16u8_front.sv
module u16u8_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [15:0]         code_unit,
  input  logic                end_of_text,
  output logic                push,
  output u16u8_pkg::job_t     job
);

  logic       held_valid_r, held_valid_nxt;
  logic [9:0] held_bits_r, held_bits_nxt;
  logic       is_low, is_high, pair;

  // Classify the unit
  assign is_low  = (code_unit[15:10] == u16u8_pkg::LOW_SURR_TAG);
  assign is_high = (code_unit[15:10] == u16u8_pkg::HIGH_SURR_TAG);
  assign pair    = held_valid_r && is_low;

  // Build the job for this beat
  always_comb begin
    job.flush      = held_valid_r && !is_low;
    job.flush_bits = held_bits_r;
    job.cur        = pair || !(is_high && !end_of_text);
    job.cp         = pair ? (u16u8_pkg::SUPP_BASE + {1'b0, held_bits_r, code_unit[9:0]})
                          : {5'd0, code_unit};
    job.eot        = end_of_text;
  end

  assign push = accept && (job.flush || job.cur);

  // Held high surrogate
  always_comb begin
    held_valid_nxt = held_valid_r;
    held_bits_nxt  = held_bits_r;
    if (accept) begin
      held_valid_nxt = is_high && !end_of_text;
      held_bits_nxt  = code_unit[9:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
      held_bits_r  <= 10'd0;
    end else begin
      held_valid_r <= held_valid_nxt;
      held_bits_r  <= held_bits_nxt;
    end
  end

endmodule

// File: sv/u16u8_queue.sv
module u16u8_queue #(
  parameter int DEPTH = u16u8_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  u16u8_pkg::job_t push_job,
  input  logic            pop,
  output logic            not_empty,
  output logic            full,
  output u16u8_pkg::job_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  u16u8_pkg::job_t  slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign not_empty = (count_r != '0);
  assign full      = (count_r == CNT_W'(DEPTH));
  assign head      = slots_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// File: sv/u16u8_back.sv
module u16u8_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_not_empty,
  input  u16u8_pkg::job_t q_head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_byte,
  output logic            out_last,
  output logic            out_done
);

  logic        active_r, active_nxt;
  logic        flush_r, flush_nxt;
  logic [9:0]  fbits_r, fbits_nxt;
  logic [20:0] cp_r, cp_nxt;
  logic [2:0]  len_r, len_nxt;
  logic [2:0]  last_idx_r, last_idx_nxt;
  logic        eot_r, eot_nxt;
  logic [2:0]  idx_r, idx_nxt;

  logic        ov_r, ov_nxt;
  logic [7:0]  ob_r, ob_nxt;
  logic        ol_r, ol_nxt;
  logic        od_r, od_nxt;

  logic        out_ld, is_last, sel_flush;
  logic [2:0]  cur_idx, head_len, head_total;
  logic [20:0] sel_cp;
  logic [2:0]  sel_len;

  assign out_ld  = active_r && (!ov_r || !out_stall);
  assign is_last = (idx_r == last_idx_r);
  assign pop     = q_not_empty && (!active_r || (out_ld && is_last));

  // Pick the code point and position for the current byte
  always_comb begin
    sel_flush = flush_r && (idx_r < u16u8_pkg::FLUSH_BYTES);
    cur_idx   = (flush_r && !sel_flush) ? (idx_r - u16u8_pkg::FLUSH_BYTES) : idx_r;
    sel_cp    = sel_flush ? {5'd0, u16u8_pkg::HIGH_SURR_TAG, fbits_r} : cp_r;
    sel_len   = sel_flush ? u16u8_pkg::FLUSH_BYTES : len_r;
  end

  // Byte counts of the job at the queue head
  always_comb begin
    head_len   = q_head.cur ? u16u8_pkg::cp_len(q_head.cp) : 3'd0;
    head_total = (q_head.flush ? u16u8_pkg::FLUSH_BYTES : 3'd0) + head_len;
  end

  // Job sequencing
  always_comb begin
    active_nxt   = active_r;
    flush_nxt    = flush_r;
    fbits_nxt    = fbits_r;
    cp_nxt       = cp_r;
    len_nxt      = len_r;
    last_idx_nxt = last_idx_r;
    eot_nxt      = eot_r;
    idx_nxt      = idx_r;
    if (pop) begin
      active_nxt   = 1'b1;
      flush_nxt    = q_head.flush;
      fbits_nxt    = q_head.flush_bits;
      cp_nxt       = q_head.cp;
      len_nxt      = head_len;
      last_idx_nxt = head_total - 3'd1;
      eot_nxt      = q_head.eot;
      idx_nxt      = 3'd0;
    end else if (out_ld && is_last) begin
      active_nxt = 1'b0;
    end else if (out_ld) begin
      idx_nxt = idx_r + 3'd1;
    end
  end

  // Output register
  always_comb begin
    ov_nxt = ov_r;
    ob_nxt = ob_r;
    ol_nxt = ol_r;
    od_nxt = od_r;
    if (out_ld) begin
      ov_nxt = 1'b1;
      ob_nxt = u16u8_pkg::cp_byte(sel_cp, sel_len, cur_idx[1:0]);
      ol_nxt = is_last;
      od_nxt = is_last && eot_r;
    end else if (!out_stall) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      active_r <= active_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    flush_r    <= flush_nxt;
    fbits_r    <= fbits_nxt;
    cp_r       <= cp_nxt;
    len_r      <= len_nxt;
    last_idx_r <= last_idx_nxt;
    eot_r      <= eot_nxt;
    idx_r      <= idx_nxt;
    ob_r       <= ob_nxt;
    ol_r       <= ol_nxt;
    od_r       <= od_nxt;
  end

  assign out_valid = ov_r;
  assign out_byte  = ob_r;
  assign out_last  = ol_r;
  assign out_done  = od_r;

endmodule

// File: sv/utf16_to_utf8_transcoder.sv
// UTF-16 to UTF-8 transcoder.
// Input channel: one UTF-16 code unit per beat (in_code_unit) with
// in_end_of_text on the last unit of a string. Output channel: one UTF-8
// byte per beat, with out_last_of_run on the last byte caused by an input
// beat and out_text_done on the final byte of the string.
// A high surrogate is held in the front until the next unit; a matching low
// surrogate makes a four-byte code point, anything else flushes the held
// unit as three bytes first. A high surrogate ending a string is flushed.
// The front classifies units and pushes jobs into a QUEUE_DEPTH-entry queue;
// the back turns each job into 1 to 6 bytes, one byte per cycle while out_stall
// is low. Throughput is bounded by the byte-wide output register; in_stall
// rises only when the queue is full. The first byte passes through the queue
// slot, the back's job registers and the output register.
// Reset (rst_n low, synchronous) drops any held surrogate, empties the queue
// and clears out_valid. When out_stall is high the output beat holds and the
// queue absorbs up to QUEUE_DEPTH further jobs before in_stall asserts.
module utf16_to_utf8_transcoder #(
  parameter int QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_code_unit,
  input  logic        in_end_of_text,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_out_byte,
  output logic        out_last_of_run,
  output logic        out_text_done
);

  logic            accept, push, pop, q_not_empty, q_full;
  u16u8_pkg::job_t push_job, head_job;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  u16u8_front front_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .code_unit   (in_code_unit),
    .end_of_text (in_end_of_text),
    .push        (push),
    .job         (push_job)
  );

  u16u8_queue #(.DEPTH(QUEUE_DEPTH)) queue_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .not_empty (q_not_empty),
    .full      (q_full),
    .head      (head_job)
  );

  u16u8_back back_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (head_job),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_out_byte),
    .out_last    (out_last_of_run),
    .out_done    (out_text_done)
  );

endmodule

// File: sv/u16u8_chk.sv
module u16u8_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [15:0] in_code_unit,
  input logic        in_end_of_text,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_out_byte,
  input logic        out_last_of_run,
  input logic        out_text_done
);

  // A stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_out_byte)
      && $stable(out_last_of_run) && $stable(out_text_done))
    else $error("output beat changed under stall");

  // End of string only on the last byte of a run
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_text_done |-> out_last_of_run)
    else $error("text_done without last_of_run");

  // No byte of the forbidden lead range 0xF8..0xFF
  a_legal_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_out_byte[7:3] != 5'b11111)
    else $error("illegal UTF-8 byte");

  // Output is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid after reset");

endmodule

bind utf16_to_utf8_transcoder u16u8_chk chk_i (.*);

// File: verif/tb_utf16_to_utf8_transcoder.sv
`timescale 1ns / 100ps

module tb_utf16_to_utf8_transcoder;

  // One expected output beat
  typedef struct packed {
    logic [7:0] data;
    logic       last_of_run;
    logic       text_done;
  } utf8_beat_t;

  // Kinds of code unit the random texts are built from
  typedef enum int {
    KIND_ASCII,
    KIND_TWO_BYTE,
    KIND_THREE_BYTE,
    KIND_PAIR,
    KIND_LONE_HIGH,
    KIND_LONE_LOW,
    KIND_ANY
  } unit_kind_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] in_code_unit = '0;
  logic        in_end_of_text = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_out_byte;
  logic        out_last_of_run;
  logic        out_text_done;

  // Transcoder state as the predictor sees it
  logic [9:0]  held_bits = '0;
  logic        held = 1'b0;

  logic [7:0]  run_bytes[$];
  utf8_beat_t  expected_bytes[$];

  bit          steady_run = 1'b0;
  int          errors = 0;
  int          units_sent = 0;
  int          texts_sent = 0;
  int          bytes_checked = 0;
  int          pairs_joined = 0;

  utf16_to_utf8_transcoder u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_code_unit    (in_code_unit),
    .in_end_of_text  (in_end_of_text),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_out_byte    (out_out_byte),
    .out_last_of_run (out_last_of_run),
    .out_text_done   (out_text_done)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Append the UTF-8 encoding of one code point to the current run
  function void append_utf8(input logic [20:0] cp);
    if (cp <= 21'h7F) begin
      run_bytes.push_back({1'b0, cp[6:0]});
    end else if (cp <= 21'h7FF) begin
      run_bytes.push_back({3'b110, cp[10:6]});
      run_bytes.push_back({2'b10, cp[5:0]});
    end else if (cp <= 21'hFFFF) begin
      run_bytes.push_back({4'b1110, cp[15:12]});
      run_bytes.push_back({2'b10, cp[11:6]});
      run_bytes.push_back({2'b10, cp[5:0]});
    end else begin
      run_bytes.push_back({5'b11110, cp[20:18]});
      run_bytes.push_back({2'b10, cp[17:12]});
      run_bytes.push_back({2'b10, cp[11:6]});
      run_bytes.push_back({2'b10, cp[5:0]});
    end
  endfunction

  // Expected bytes for one accepted code unit; updates the held surrogate
  function void predict_utf8(input logic [15:0] unit, input logic eot);
    logic is_high;
    logic is_low;
    logic paired;
    int   n;
    is_high = (unit[15:10] == u16u8_pkg::HIGH_SURR_TAG);
    is_low  = (unit[15:10] == u16u8_pkg::LOW_SURR_TAG);
    paired  = 1'b0;
    run_bytes.delete();
    if (held) begin
      if (is_low) begin
        append_utf8({1'b0, held_bits, unit[9:0]} + 21'h10000);
        paired = 1'b1;
        pairs_joined++;
      end else begin
        // held high surrogate goes out on its own
        append_utf8({5'd0, u16u8_pkg::HIGH_SURR_TAG, held_bits});
      end
      held      = 1'b0;
      held_bits = '0;
    end
    if (!paired) begin
      if (is_high && !eot) begin
        held_bits = unit[9:0];
        held      = 1'b1;
      end else begin
        append_utf8({5'd0, unit});
      end
    end
    if (eot) begin
      held      = 1'b0;
      held_bits = '0;
    end
    n = run_bytes.size();
    foreach (run_bytes[i]) begin
      expected_bytes.push_back('{data: run_bytes[i],
                                 last_of_run: (i == n - 1),
                                 text_done: (i == n - 1) && eot});
    end
  endfunction

  // Drive one code unit, with a random gap first, and wait for its beat
  task automatic send_unit(input logic [15:0] unit, input logic eot);
    int gap;
    gap = 0;
    if (!steady_run && $urandom_range(0, 99) < 24) gap = $urandom_range(1, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_code_unit   <= unit;
    in_end_of_text <= eot;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_utf8(unit, eot);
    units_sent++;
    if (eot) texts_sent++;
  endtask

  // Check output beats; the result side stalls at random outside steady runs
  always @(posedge clk) begin
    utf8_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      bytes_checked++;
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected byte %02h (last_of_run %0b, text_done %0b)",
                 $time, out_out_byte, out_last_of_run, out_text_done);
        errors++;
      end else begin
        want = expected_bytes.pop_front();
        if (out_out_byte !== want.data) begin
          $display("%0t: out_byte expected %02h, got %02h", $time, want.data, out_out_byte);
          errors++;
        end
        if (out_last_of_run !== want.last_of_run) begin
          $display("%0t: last_of_run expected %0b, got %0b", $time, want.last_of_run,
                   out_last_of_run);
          errors++;
        end
        if (out_text_done !== want.text_done) begin
          $display("%0t: text_done expected %0b, got %0b", $time, want.text_done,
                   out_text_done);
          errors++;
        end
      end
    end
    out_stall <= steady_run ? 1'b0 : ($urandom_range(0, 99) < 24);
  end

  // Smallest and largest one-byte units
  task automatic test_one_byte();
    send_unit(16'h0000, 1'b0);
    send_unit(16'h007F, 1'b1);
  endtask

  // Two-byte range edges
  task automatic test_two_byte();
    send_unit(16'h0080, 1'b0);
    send_unit(16'h07FF, 1'b1);
  endtask

  // Three-byte range edges around the surrogate block
  task automatic test_three_byte();
    send_unit(16'h0800, 1'b0);
    send_unit(16'hD7FF, 1'b0);
    send_unit(16'hE000, 1'b0);
    send_unit(16'hFFFF, 1'b1);
  endtask

  // Lowest and highest supplementary points
  task automatic test_surrogate_pair();
    send_unit(16'hD800, 1'b0);
    send_unit(16'hDC00, 1'b0);
    send_unit(16'hDBFF, 1'b0);
    send_unit(16'hDFFF, 1'b1);
  endtask

  // Held high surrogate followed by a non-low unit, and by another high one
  task automatic test_held_then_other();
    send_unit(16'hD800, 1'b0);
    send_unit(16'h0041, 1'b0);
    send_unit(16'hD9AB, 1'b0);
    send_unit(16'hD800, 1'b0);
    send_unit(16'hDC01, 1'b1);
  endtask

  // High surrogate as the last unit is flushed at once
  task automatic test_high_ends_text();
    send_unit(16'hDBFF, 1'b1);
    // held one plus closing one: six bytes from one beat
    send_unit(16'hD800, 1'b0);
    send_unit(16'hDBFF, 1'b1);
  endtask

  // Low surrogates with nothing held
  task automatic test_unpaired_low();
    send_unit(16'hDC00, 1'b0);
    send_unit(16'hDFFF, 1'b1);
  endtask

  // One random text of 1 to 9 units, mostly well formed
  task automatic send_random_text();
    int         len;
    int         k;
    int         pick;
    unit_kind_t kind;
    logic [15:0] unit;
    len = $urandom_range(1, 8);
    k = 0;
    while (k < len) begin
      pick = $urandom_range(0, 99);
      if (pick < 15)      kind = KIND_ASCII;
      else if (pick < 30) kind = KIND_TWO_BYTE;
      else if (pick < 45) kind = KIND_THREE_BYTE;
      else if (pick < 75) kind = KIND_PAIR;
      else if (pick < 82) kind = KIND_LONE_HIGH;
      else if (pick < 89) kind = KIND_LONE_LOW;
      else                kind = KIND_ANY;
      case (kind)
        KIND_ASCII:      unit = 16'($urandom_range(0, 16'h7F));
        KIND_TWO_BYTE:   unit = 16'($urandom_range(16'h80, 16'h7FF));
        KIND_THREE_BYTE: begin
          if ($urandom_range(0, 1)) unit = 16'($urandom_range(16'h800, 16'hD7FF));
          else unit = 16'($urandom_range(16'hE000, 16'hFFFF));
        end
        KIND_PAIR: begin
          send_unit({u16u8_pkg::HIGH_SURR_TAG, 10'($urandom)}, 1'b0);
          k++;
          unit = {u16u8_pkg::LOW_SURR_TAG, 10'($urandom)};
        end
        KIND_LONE_HIGH:  unit = {u16u8_pkg::HIGH_SURR_TAG, 10'($urandom)};
        KIND_LONE_LOW:   unit = {u16u8_pkg::LOW_SURR_TAG, 10'($urandom)};
        default:         unit = 16'($urandom);
      endcase
      send_unit(unit, k >= len - 1);
      k++;
    end
  endtask

  // Random texts with idling on both sides
  task automatic test_random_text(input int n_units);
    int target;
    target = units_sent + n_units;
    while (units_sent < target) send_random_text();
  endtask

  // Back-to-back beats with no gaps and no output stalls
  task automatic test_steady_burst(input int n_units);
    steady_run = 1'b1;
    test_random_text(n_units);
    steady_run = 1'b0;
  endtask

  initial begin
    rst_n <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_one_byte();
    test_two_byte();
    test_three_byte();
    test_surrogate_pair();
    test_held_then_other();
    test_high_ends_text();
    test_unpaired_low();
    test_random_text(60);
    test_steady_burst(35);
    test_random_text(45);

    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d code units in %0d texts, %0d surrogate pairs joined.",
             units_sent, texts_sent, pairs_joined);
    $display("Checked %0d UTF-8 bytes, %0d mismatches.", bytes_checked, errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("Timeout with %0d bytes still expected.", expected_bytes.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
